[hw/rtl/shifting_array_table_top_assert.svh]
// assertion macros for the shifting array table
`ifndef SHIFTING_ARRAY_TABLE_TOP_ASSERT_SVH
`define SHIFTING_ARRAY_TABLE_TOP_ASSERT_SVH
`ifndef SYNTH
`define SAT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define SAT_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SAT_ASSERT(label, prop, msg)
`define SAT_ASSERT_RST(label, prop, msg)
`endif
`endif

[hw/rtl/sat_pkg.sv]
package sat_pkg;

   localparam int DEPTH    = 64;
   localparam int AW       = $clog2(DEPTH);
   localparam int CW       = $clog2(DEPTH + 1);
   localparam int CMPW     = (CW > 7) ? CW : 7;
   localparam int SHOW_MAX = (DEPTH < 64) ? DEPTH : 64;

   typedef enum logic [2:0] {
      CMD_CLEAR   = 3'd0,
      CMD_DISPLAY = 3'd1,
      CMD_INSERT  = 3'd2,
      CMD_DELETE  = 3'd3,
      CMD_SEARCH  = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_INDEX = 3'd1,
      ST_FULL      = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef struct packed {
      logic        [2:0]  command;
      logic signed [7:0]  position;
      logic signed [31:0] item_value;
   } sat_req_type;

   typedef struct packed {
      logic        [2:0]  status;
      logic        [5:0]  found_index;
      logic signed [31:0] element;
      logic        [6:0]  fill_count;
      logic               last;
   } sat_rsp_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_TAKE,
      DP_CLEAR,
      DP_INIT_UP,
      DP_INIT_DN,
      DP_INIT_SCAN,
      DP_INIT_SHOW,
      DP_STEP_UP,
      DP_STEP_DN,
      DP_STEP_SCAN,
      DP_STEP_SHOW,
      DP_PUT_VAL,
      DP_DEC,
      DP_REPLY
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      status_type code;
   } dp_ctl_type;

   typedef struct packed {
      logic [2:0] command;
      logic       ins_ok;
      logic       del_ok;
      logic       full;
      logic       empty;
      logic       walk_done;
      logic       hit;
      logic       out_free;
   } dp_sts_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_DISPATCH,
      CS_SHIFT_UP,
      CS_SHIFT_DN,
      CS_SCAN,
      CS_SHOW,
      CS_REPLY
   } ctl_state_type;

endpackage

[hw/rtl/sat_ram.sv]
module sat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[hw/rtl/sat_dp.sv]
`include "shifting_array_table_top_assert.svh"

module sat_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  sat_pkg::sat_req_type req_data,
   input  sat_pkg::dp_ctl_type  ctl,
   output sat_pkg::dp_sts_type  sts,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output sat_pkg::sat_rsp_type rsp_data
);
   import sat_pkg::*;

   sat_req_type       item_ff, item_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     rem_ff, rem_in;
   logic [AW-1:0]     src_ff, src_in;
   logic [AW-1:0]     last_ff, last_in;
   logic              rd_ok_ff, rd_ok_in;
   logic [AW-1:0]     rep_idx_ff, rep_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   sat_rsp_type       rsp_data_ff, rsp_data_in;

   logic              ram_we, ram_re;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [31:0]       ram_wdata, ram_rdata;

   logic [CMPW-1:0]   pos_u;
   logic [CW-1:0]     pos_c;
   logic [AW-1:0]     pos_a;
   logic              out_free;
   logic              advance;
   logic              hit;

   sat_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign pos_u    = CMPW'(item_ff.position[6:0]);
   assign pos_c    = CW'(pos_u);
   assign pos_a    = AW'(pos_u);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign advance  = !rd_ok_ff || out_free;
   assign hit      = rd_ok_ff && (ram_rdata == item_ff.item_value);

   always_comb begin
      sts.command   = item_ff.command;
      sts.ins_ok    = !item_ff.position[7] && (pos_u <= CMPW'(count_ff));
      sts.del_ok    = !item_ff.position[7] && (pos_u < CMPW'(count_ff));
      sts.full      = (count_ff == CW'(DEPTH));
      sts.empty     = (count_ff == '0);
      sts.walk_done = (rem_ff == '0) && !rd_ok_ff;
      sts.hit       = hit;
      sts.out_free  = out_free;
   end

   always_comb begin
      item_in      = item_ff;
      count_in     = count_ff;
      rem_in       = rem_ff;
      src_in       = src_ff;
      last_in      = last_ff;
      rd_ok_in     = rd_ok_ff;
      rep_idx_in   = rep_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = last_ff + AW'(1);
      ram_wdata    = ram_rdata;
      ram_re       = 1'b0;
      ram_raddr    = src_ff;
      unique case (ctl.op)
         DP_NOP: begin
         end
         DP_TAKE: begin
            item_in    = req_data;
            rep_idx_in = '0;
         end
         DP_CLEAR: begin
            count_in = '0;
         end
         DP_INIT_UP: begin
            rem_in   = count_ff - pos_c;
            src_in   = AW'(count_ff - CW'(1));
            rd_ok_in = 1'b0;
         end
         DP_INIT_DN: begin
            rem_in   = count_ff - pos_c - CW'(1);
            src_in   = pos_a + AW'(1);
            rd_ok_in = 1'b0;
         end
         DP_INIT_SCAN: begin
            rem_in   = count_ff;
            src_in   = '0;
            rd_ok_in = 1'b0;
         end
         DP_INIT_SHOW: begin
            rem_in   = (count_ff > CW'(SHOW_MAX)) ? CW'(SHOW_MAX) : count_ff;
            src_in   = '0;
            rd_ok_in = 1'b0;
         end
         DP_STEP_UP: begin
            ram_we = rd_ok_ff;
            if (rem_ff != '0) begin
               ram_re   = 1'b1;
               last_in  = src_ff;
               src_in   = src_ff - AW'(1);
               rem_in   = rem_ff - CW'(1);
               rd_ok_in = 1'b1;
            end else begin
               rd_ok_in = 1'b0;
            end
         end
         DP_STEP_DN: begin
            ram_we    = rd_ok_ff;
            ram_waddr = last_ff - AW'(1);
            if (rem_ff != '0) begin
               ram_re   = 1'b1;
               last_in  = src_ff;
               src_in   = src_ff + AW'(1);
               rem_in   = rem_ff - CW'(1);
               rd_ok_in = 1'b1;
            end else begin
               rd_ok_in = 1'b0;
            end
         end
         DP_STEP_SCAN: begin
            if (hit) begin
               rep_idx_in = last_ff;
            end
            if (rem_ff != '0) begin
               ram_re   = 1'b1;
               last_in  = src_ff;
               src_in   = src_ff + AW'(1);
               rem_in   = rem_ff - CW'(1);
               rd_ok_in = 1'b1;
            end else begin
               rd_ok_in = 1'b0;
            end
         end
         DP_STEP_SHOW: begin
            if (rd_ok_ff && out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = ST_OK;
               rsp_data_in.found_index = 6'(last_ff);
               rsp_data_in.element     = ram_rdata;
               rsp_data_in.fill_count  = 7'(count_ff);
               rsp_data_in.last        = (rem_ff == '0);
            end
            if (advance) begin
               if (rem_ff != '0) begin
                  ram_re   = 1'b1;
                  last_in  = src_ff;
                  src_in   = src_ff + AW'(1);
                  rem_in   = rem_ff - CW'(1);
                  rd_ok_in = 1'b1;
               end else begin
                  rd_ok_in = 1'b0;
               end
            end
         end
         DP_PUT_VAL: begin
            ram_we    = 1'b1;
            ram_waddr = pos_a;
            ram_wdata = item_ff.item_value;
            count_in  = count_ff + CW'(1);
         end
         DP_DEC: begin
            count_in = count_ff - CW'(1);
         end
         DP_REPLY: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = ctl.code;
               rsp_data_in.found_index = 6'(rep_idx_ff);
               rsp_data_in.element     = '0;
               rsp_data_in.fill_count  = 7'(count_ff);
               rsp_data_in.last        = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_ok_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_ok_ff     <= rd_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      rem_ff      <= rem_in;
      src_ff      <= src_in;
      last_ff     <= last_in;
      rep_idx_ff  <= rep_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SAT_ASSERT_RST(a_count_bound, reset || (count_ff <= CW'(DEPTH)), "fill count above depth")
   `SAT_ASSERT(a_count_step, (count_ff != $past(count_ff)) |-> ((count_ff == $past(count_ff) + CW'(1)) || (count_ff == $past(count_ff) - CW'(1)) || (count_ff == '0)), "fill count jumped")
   `SAT_ASSERT(a_no_collide, ram_we |-> (!ram_re || (ram_waddr != ram_raddr)), "ram read and write hit one entry")
   `SAT_ASSERT(a_put_room, (ctl.op == DP_PUT_VAL) |-> (count_ff < CW'(DEPTH)), "insert into full table")

endmodule

[hw/rtl/sat_ctrl.sv]
module sat_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sat_pkg::dp_sts_type sts,
   output sat_pkg::dp_ctl_type ctl
);
   import sat_pkg::*;

   ctl_state_type state_ff, state_in;
   status_type    code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      code_ff <= code_in;
   end

   always_comb begin
      state_in  = state_ff;
      code_in   = code_ff;
      req_ready = 1'b0;
      ctl.op    = DP_NOP;
      ctl.code  = code_ff;
      unique case (state_ff)
         CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.op   = DP_TAKE;
               state_in = CS_DISPATCH;
            end
         end
         CS_DISPATCH: begin
            state_in = CS_REPLY;
            code_in  = ST_OK;
            unique case (sts.command)
               CMD_CLEAR: begin
                  ctl.op = DP_CLEAR;
               end
               CMD_DISPLAY: begin
                  if (sts.empty) begin
                     code_in = ST_EMPTY;
                  end else begin
                     ctl.op   = DP_INIT_SHOW;
                     state_in = CS_SHOW;
                  end
               end
               CMD_INSERT: begin
                  if (!sts.ins_ok) begin
                     code_in = ST_BAD_INDEX;
                  end else if (sts.full) begin
                     code_in = ST_FULL;
                  end else begin
                     ctl.op   = DP_INIT_UP;
                     state_in = CS_SHIFT_UP;
                  end
               end
               CMD_DELETE: begin
                  if (!sts.del_ok) begin
                     code_in = ST_BAD_INDEX;
                  end else begin
                     ctl.op   = DP_INIT_DN;
                     state_in = CS_SHIFT_DN;
                  end
               end
               CMD_SEARCH: begin
                  ctl.op   = DP_INIT_SCAN;
                  state_in = CS_SCAN;
               end
               default: begin
                  code_in = ST_BAD_INDEX;
               end
            endcase
         end
         CS_SHIFT_UP: begin
            if (sts.walk_done) begin
               ctl.op   = DP_PUT_VAL;
               code_in  = ST_OK;
               state_in = CS_REPLY;
            end else begin
               ctl.op = DP_STEP_UP;
            end
         end
         CS_SHIFT_DN: begin
            if (sts.walk_done) begin
               ctl.op   = DP_DEC;
               code_in  = ST_OK;
               state_in = CS_REPLY;
            end else begin
               ctl.op = DP_STEP_DN;
            end
         end
         CS_SCAN: begin
            if (sts.hit) begin
               ctl.op   = DP_STEP_SCAN;
               code_in  = ST_OK;
               state_in = CS_REPLY;
            end else if (sts.walk_done) begin
               code_in  = ST_NOT_FOUND;
               state_in = CS_REPLY;
            end else begin
               ctl.op = DP_STEP_SCAN;
            end
         end
         CS_SHOW: begin
            if (sts.walk_done) begin
               state_in = CS_IDLE;
            end else begin
               ctl.op = DP_STEP_SHOW;
            end
         end
         CS_REPLY: begin
            ctl.op = DP_REPLY;
            if (sts.out_free) begin
               state_in = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

endmodule

[hw/rtl/shifting_array_table_top.sv]
// insert and delete: one element per cycle, through the one read port and the one
// write port of the element ram
// search: stops at the first match; display: one element per cycle unstalled
// a new request is taken once the result sits in the output register
// synchronous reset empties the table and drops any pending result; ram is not cleared
module shifting_array_table_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sat_pkg::sat_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sat_pkg::sat_rsp_type rsp_data
);
   import sat_pkg::*;

   dp_ctl_type ctl;
   dp_sts_type sts;

   sat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   sat_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

[bench/shifting_array_table_checker.sv]
module shifting_array_table_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  sat_pkg::sat_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  sat_pkg::sat_rsp_type rsp_data,
   output int unsigned          fail_count,
   output int unsigned          pending_count
);
   import sat_pkg::*;

   logic signed [31:0] table_mem [DEPTH];
   int                 table_fill;
   sat_rsp_type        rsp_expect_q [$];
   sat_rsp_type        due_rsp;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      table_fill    = 0;
   end

   task automatic push_rsp(input status_type st, input int idx,
                           input logic [31:0] value, input logic is_last);
      sat_rsp_type r;
      r.status      = st;
      r.found_index = 6'(idx);
      r.element     = value;
      r.fill_count  = 7'(table_fill);
      r.last        = is_last;
      rsp_expect_q.push_back(r);
   endtask

   task automatic apply_command(input sat_req_type r);
      int pos;
      int n;
      int hit_idx;
      pos     = r.position;
      hit_idx = -1;
      case (r.command)
         CMD_CLEAR: begin
            table_fill = 0;
            push_rsp(ST_OK, 0, '0, 1'b1);
         end
         CMD_DISPLAY: begin
            if (table_fill == 0) begin
               push_rsp(ST_EMPTY, 0, '0, 1'b1);
            end else begin
               n = (table_fill > SHOW_MAX) ? SHOW_MAX : table_fill;
               for (int i = 0; i < n; i++)
                  push_rsp(ST_OK, i, table_mem[i], i + 1 == n);
            end
         end
         CMD_INSERT: begin
            if (pos < 0 || pos > table_fill) begin
               push_rsp(ST_BAD_INDEX, 0, '0, 1'b1);
            end else if (table_fill >= DEPTH) begin
               push_rsp(ST_FULL, 0, '0, 1'b1);
            end else begin
               for (int i = table_fill; i > pos; i--)
                  table_mem[i] = table_mem[i - 1];
               table_mem[pos] = r.item_value;
               table_fill++;
               push_rsp(ST_OK, 0, '0, 1'b1);
            end
         end
         CMD_DELETE: begin
            if (pos < 0 || pos >= table_fill) begin
               push_rsp(ST_BAD_INDEX, 0, '0, 1'b1);
            end else begin
               for (int i = pos; i + 1 < table_fill; i++)
                  table_mem[i] = table_mem[i + 1];
               table_fill--;
               push_rsp(ST_OK, 0, '0, 1'b1);
            end
         end
         CMD_SEARCH: begin
            for (int i = 0; i < table_fill; i++) begin
               if (hit_idx < 0 && table_mem[i] == r.item_value)
                  hit_idx = i;
            end
            if (hit_idx >= 0)
               push_rsp(ST_OK, hit_idx, '0, 1'b1);
            else
               push_rsp(ST_NOT_FOUND, 0, '0, 1'b1);
         end
         default: begin
            push_rsp(ST_BAD_INDEX, 0, '0, 1'b1);
         end
      endcase
   endtask

   task automatic report_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
      $display("%0t: rsp %s mismatch, expected %0h, got %0h", $time, field, want, got);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         table_fill = 0;
         rsp_expect_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_expect_q.size() == 0) begin
               $display("%0t: unexpected rsp transfer, expected none, got %p",
                        $time, rsp_data);
               fail_count++;
            end else begin
               due_rsp = rsp_expect_q.pop_front();
               if (rsp_data.status !== due_rsp.status)
                  report_field("status", due_rsp.status, rsp_data.status);
               if (rsp_data.found_index !== due_rsp.found_index)
                  report_field("found_index", due_rsp.found_index, rsp_data.found_index);
               if (rsp_data.element !== due_rsp.element)
                  report_field("element", due_rsp.element, rsp_data.element);
               if (rsp_data.fill_count !== due_rsp.fill_count)
                  report_field("fill_count", due_rsp.fill_count, rsp_data.fill_count);
               if (rsp_data.last !== due_rsp.last)
                  report_field("last", due_rsp.last, rsp_data.last);
            end
         end
         if (req_valid && req_ready)
            apply_command(req_data);
      end
      pending_count = rsp_expect_q.size();
   end

endmodule

[bench/tb_shifting_array_table_top.sv]
module tb_shifting_array_table_top;
   import sat_pkg::*;

   localparam logic [2:0] CMD_RESERVED_FIRST = 3'd5;
   localparam int         RANDOM_ITEMS       = 250;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   sat_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   sat_rsp_type rsp_data;

   int unsigned fail_count;
   int unsigned pending_count;

   int          shadow_fill  = 0;
   int          burst_left   = 0;
   int          random_sent  = 0;
   logic [31:0] recent_value = '0;

   int          stall_mode   = 0;
   int          stall_left   = 0;
   int          stall_phase  = 0;

   shifting_array_table_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   shifting_array_table_checker table_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stall pattern, switching among four modes at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
         end
         stall_left--;
         stall_phase++;
         case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            2:       rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (stall_phase % 11) < 3;
         endcase
      end
   end

   function automatic sat_req_type make_req(input logic [2:0] op, input int pos,
                                            input logic [31:0] value);
      sat_req_type r;
      r.command    = op;
      r.position   = 8'(pos);
      r.item_value = value;
      return r;
   endfunction

   function automatic logic [31:0] pick_value();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 5)
         return 32'(int'($urandom_range(0, 15)) - 8);
      else if (roll == 5)
         return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      else if (roll == 6)
         return recent_value;
      return $urandom();
   endfunction

   function automatic int bad_pos(input int first_bad);
      case ($urandom_range(0, 3))
         0:       return -1;
         1:       return first_bad;
         2:       return $urandom_range(first_bad, 127);
         default: return -int'($urandom_range(1, 128));
      endcase
   endfunction

   task automatic send_req(input sat_req_type item);
      int gap;
      int pos;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pos = item.position;
      case (item.command)
         CMD_CLEAR: shadow_fill = 0;
         CMD_INSERT: begin
            recent_value = item.item_value;
            if (pos >= 0 && pos <= shadow_fill && shadow_fill < DEPTH)
               shadow_fill++;
         end
         CMD_DELETE: begin
            if (pos >= 0 && pos < shadow_fill)
               shadow_fill--;
         end
         default: ;
      endcase
   endtask

   task automatic send_random(input int insert_pct);
      int roll;
      int pos;
      random_sent++;
      if ($urandom_range(0, 99) < insert_pct) begin
         pos = ($urandom_range(0, 99) < 88) ? $urandom_range(0, shadow_fill)
                                           : bad_pos(shadow_fill + 1);
         send_req(make_req(CMD_INSERT, pos, pick_value()));
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 35) begin
            pos = (shadow_fill > 0 && $urandom_range(0, 99) < 88)
                  ? $urandom_range(0, shadow_fill - 1) : bad_pos(shadow_fill);
            send_req(make_req(CMD_DELETE, pos, $urandom()));
         end else if (roll < 72) begin
            send_req(make_req(CMD_SEARCH, $urandom_range(0, 255), pick_value()));
         end else if (roll < 84) begin
            send_req(make_req(CMD_DISPLAY, $urandom_range(0, 255), $urandom()));
         end else if (roll < 88) begin
            send_req(make_req(CMD_CLEAR, $urandom_range(0, 255), $urandom()));
         end else begin
            send_req(make_req(3'(CMD_RESERVED_FIRST + $urandom_range(0, 2)),
                              $urandom_range(0, 255), $urandom()));
         end
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      @(posedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty table corner cases, then a small table with extremes and duplicates
      send_req(make_req(CMD_CLEAR, 0, 32'd0));
      send_req(make_req(CMD_DISPLAY, 0, 32'd0));
      send_req(make_req(CMD_SEARCH, 0, 32'd0));
      send_req(make_req(CMD_DELETE, 0, 32'd0));
      send_req(make_req(CMD_INSERT, -1, 32'd1));
      send_req(make_req(CMD_INSERT, 1, 32'd1));
      send_req(make_req(CMD_INSERT, 0, 32'h7fff_ffff));
      send_req(make_req(CMD_INSERT, 1, 32'h8000_0000));
      send_req(make_req(CMD_INSERT, 1, 32'd0));
      send_req(make_req(CMD_INSERT, 0, 32'hffff_ffff));
      send_req(make_req(CMD_INSERT, 4, 32'd0));
      send_req(make_req(CMD_SEARCH, 0, 32'd0));
      send_req(make_req(CMD_SEARCH, 0, 32'h8000_0000));
      send_req(make_req(CMD_SEARCH, 0, 32'd5));
      send_req(make_req(CMD_DISPLAY, 0, 32'd0));
      send_req(make_req(CMD_DELETE, 5, 32'd0));
      send_req(make_req(CMD_DELETE, -128, 32'd0));
      send_req(make_req(CMD_INSERT, 127, 32'hffff_ffff));
      send_req(make_req(CMD_DELETE, 0, 32'd0));
      send_req(make_req(CMD_DELETE, 3, 32'd0));
      send_req(make_req(CMD_DELETE, 1, 32'd0));
      for (int k = 0; k < 3; k++)
         send_req(make_req(3'(CMD_RESERVED_FIRST + k), 0, 32'd0));
      send_req(make_req(CMD_DISPLAY, 0, 32'd0));

      drain();

      for (int k = 0; k < 90; k++)
         send_random(50);

      // fill to capacity, then hit the full table
      while (shadow_fill < DEPTH) begin
         random_sent++;
         send_req(make_req(CMD_INSERT, $urandom_range(0, shadow_fill), pick_value()));
      end
      send_req(make_req(CMD_INSERT, 0, pick_value()));
      send_req(make_req(CMD_INSERT, DEPTH, pick_value()));
      send_req(make_req(CMD_INSERT, DEPTH + 1, pick_value()));
      send_req(make_req(CMD_DISPLAY, 0, 32'd0));
      send_req(make_req(CMD_SEARCH, 0, recent_value));
      send_req(make_req(CMD_DELETE, DEPTH - 1, 32'd0));
      send_req(make_req(CMD_INSERT, DEPTH - 1, pick_value()));
      send_req(make_req(CMD_DISPLAY, 0, 32'd0));

      while (random_sent < RANDOM_ITEMS)
         send_random(40);

      drain();
      repeat (80) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
